// File: src/crc8fc_pkg.sv
// ----------------------------------------------------------------------------
// crc8fc_pkg
// Shared constants, verdict codes and the CRC-8 byte update for the framed
// packet checker.
// ----------------------------------------------------------------------------
package crc8fc_pkg;

  // Largest buffer that is counted; later bytes of a buffer are dropped.
  localparam int unsigned MAX_BUFFER = 2048;
  localparam int unsigned CNT_W      = $clog2(MAX_BUFFER + 1);

  localparam int unsigned PLEN_W  = 16;
  localparam int unsigned FLEN_W  = PLEN_W + 1;

  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [7:0] END_BYTE   = 8'h16;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [3:0] MIN_LEN    = 4'd9;

  // Positions of the start byte and the length bytes, and the first position
  // where the frame length is known.
  localparam logic [CNT_W-1:0] POS_START  = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_LEN_HI = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_LEN_LO = CNT_W'(6);
  localparam logic [CNT_W-1:0] POS_LEN_OK = CNT_W'(7);

  typedef enum logic [2:0] {
    RSN_OK        = 3'd0,
    RSN_BAD_START = 3'd1,
    RSN_SHORT     = 3'd2,
    RSN_TRUNC     = 3'd3,
    RSN_BAD_END   = 3'd4,
    RSN_BAD_CRC   = 3'd5
  } reason_t;

  // CRC-8, polynomial 0x07, data taken MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      c = {c[6:0], 1'b0} ^ ((c[7] ^ b[i]) ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

// File: src/crc8_frame_checker.sv
// ----------------------------------------------------------------------------
// crc8_frame_checker
// Streams a received buffer a byte at a time and gives one verdict on the
// buffer's last byte: frame valid, or the first check that failed.
// ----------------------------------------------------------------------------

// The checker takes one byte per clock cycle. Each accepted byte updates the
// position counter, the running CRC-8 (one byte of the 0x07 polynomial per
// cycle) and the sticky check flags; the byte flagged by in_tlast also forms
// the verdict, which appears in the output register in the next cycle while
// the next buffer's first byte can already be accepted. in_tready goes low only
// while a verdict sits in the output register and the downstream side does
// not take it. A frame starts with 0x68, carries its payload length big-endian
// in bytes 5 and 6, is payload length plus 9 bytes long, ends with 0x16 and
// has the CRC of all earlier bytes just before the end byte. Bytes after the
// frame are ignored, and bytes beyond the first 2048 of a buffer are dropped.
// The verdict reason codes, checked in this order, are: 1 bad start byte,
// 2 fewer than 9 bytes, 3 frame longer than the buffer, 4 bad end byte,
// 5 CRC mismatch; 0 means the frame is good.
module crc8_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  // Input request stream.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  // Verdict stream.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] frame_ok, [3:1] fail_reason, [7:4] zero
);
  import crc8fc_pkg::*;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        crc_r, crc_nxt;
  logic [PLEN_W-1:0] plen_r, plen_nxt;
  logic              start_bad_r, start_bad_nxt;
  logic              end_bad_r, end_bad_nxt;
  logic              crc_bad_r, crc_bad_nxt;

  logic              out_valid_r;
  logic              out_ok_r, out_ok_nxt;
  reason_t           out_reason_r, out_reason_nxt;

  logic              in_acc;
  logic              in_range;
  logic [FLEN_W-1:0] pos_ext;
  logic [FLEN_W-1:0] flen;
  logic [FLEN_W-1:0] crc_pos;
  logic [FLEN_W-1:0] end_pos;

  // A new request is taken unless a finished verdict is still stuck.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign in_range = (count_r < CNT_W'(MAX_BUFFER));
  assign pos_ext  = FLEN_W'(count_r);
  assign flen     = FLEN_W'(plen_nxt) + FLEN_W'(MIN_LEN);
  assign crc_pos  = flen - FLEN_W'(2);
  assign end_pos  = flen - FLEN_W'(1);

  // Per-byte update of the frame state.
  always_comb begin
    count_nxt     = count_r;
    plen_nxt      = plen_r;
    start_bad_nxt = start_bad_r;
    if (in_range) begin
      if (count_r == POS_START) begin
        start_bad_nxt = (in_tdata[7:0] != START_BYTE);
      end
      if (count_r == POS_LEN_HI) begin
        plen_nxt = {in_tdata[7:0], plen_r[7:0]};
      end
      if (count_r == POS_LEN_LO) begin
        plen_nxt = {plen_r[15:8], in_tdata[7:0]};
      end
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // The CRC and end checks depend on plen_nxt, so they sit in a second block.
  logic [7:0] crc_upd;
  logic       crc_bad_upd, end_bad_upd;

  always_comb begin
    crc_upd     = crc_r;
    crc_bad_upd = crc_bad_r;
    end_bad_upd = end_bad_r;
    if (in_range) begin
      if ((count_r < POS_LEN_OK) || (pos_ext < crc_pos)) begin
        crc_upd = crc8_byte(crc_r, in_tdata[7:0]);
      end else if (pos_ext == crc_pos) begin
        crc_bad_upd = (in_tdata[7:0] != crc_r);
      end else if (pos_ext == end_pos) begin
        end_bad_upd = (in_tdata[7:0] != END_BYTE);
      end
    end
  end

  // Verdict, from the state as it stands after this byte.
  always_comb begin
    priority if (start_bad_nxt) begin
      out_reason_nxt = RSN_BAD_START;
    end else if (count_nxt < CNT_W'(MIN_LEN)) begin
      out_reason_nxt = RSN_SHORT;
    end else if (flen > FLEN_W'(count_nxt)) begin
      out_reason_nxt = RSN_TRUNC;
    end else if (end_bad_upd) begin
      out_reason_nxt = RSN_BAD_END;
    end else if (crc_bad_upd) begin
      out_reason_nxt = RSN_BAD_CRC;
    end else begin
      out_reason_nxt = RSN_OK;
    end
    out_ok_nxt = (out_reason_nxt == RSN_OK);
  end

  assign crc_nxt = crc_upd;
  assign crc_bad_nxt = crc_bad_upd;
  assign end_bad_nxt = end_bad_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      crc_r       <= '0;
      plen_r      <= '0;
      start_bad_r <= 1'b0;
      end_bad_r   <= 1'b0;
      crc_bad_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        if (in_tlast) begin
          // Verdict given; the next byte opens a new buffer.
          count_r     <= '0;
          crc_r       <= '0;
          plen_r      <= '0;
          start_bad_r <= 1'b0;
          end_bad_r   <= 1'b0;
          crc_bad_r   <= 1'b0;
          out_valid_r <= 1'b1;
        end else begin
          count_r     <= count_nxt;
          crc_r       <= crc_nxt;
          plen_r      <= plen_nxt;
          start_bad_r <= start_bad_nxt;
          end_bad_r   <= end_bad_nxt;
          crc_bad_r   <= crc_bad_nxt;
        end
      end
    end
  end

  // Verdict payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      out_ok_r     <= out_ok_nxt;
      out_reason_r <= out_reason_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_reason_r, out_ok_r};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BUFFER))
    else $error("byte counter beyond buffer limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> count_r == '0 && crc_r == 8'h00 && !start_bad_r)
    else $error("frame state not cleared after last byte");

  a_verdict_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> out_tvalid)
    else $error("no verdict after last byte");

  a_ok_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0] == (out_tdata[3:1] == RSN_OK))
    else $error("frame_ok disagrees with fail_reason");

  a_no_spurious_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_acc && in_tlast))
    else $error("verdict without a last byte");
`endif

endmodule
